### hdl/jos_pkg.sv
package jos_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 256;
  localparam int AW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW         = $clog2(RING_DEPTH + 1);   // loaded count, 0..RING_DEPTH
  localparam int MW         = CW + 1;                   // ring size under test, up to n+1

  // Payload and register widths
  localparam int VALUE_W    = 32;
  localparam int SKIP_W     = 16;
  localparam logic [SKIP_W-1:0] SKIP_RESET = SKIP_W'(2);

  // Remainder unit: (pos + k) is shifted in one bit per cycle
  localparam int SUM_W      = ((SKIP_W > AW) ? SKIP_W : AW) + 1;
  localparam int BW         = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  // APB
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  typedef logic [PADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_SKIP_COUNT = reg_idx_t'(0);

  // Microcode
  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_NOSTART,
    J_MGTN,
    J_BITS,
    J_OUTBUSY
  } jump_e;

  typedef logic [2:0] upc_t;

  localparam upc_t U_IDLE = 3'd0;
  localparam upc_t U_INIT = 3'd1;
  localparam upc_t U_TEST = 3'd2;
  localparam upc_t U_LOAD = 3'd3;
  localparam upc_t U_DIV  = 3'd4;
  localparam upc_t U_NEXT = 3'd5;
  localparam upc_t U_READ = 3'd6;
  localparam upc_t U_EMIT = 3'd7;

  typedef struct packed {
    logic  accept;    // take input requests
    logic  init;      // pos = 0, m = 2
    logic  ld_div;    // load pos + k into the remainder unit
    logic  div_step;  // one restoring step
    logic  next_m;    // pos = remainder, m = m + 1
    logic  rd;        // read ring entry at pos
    logic  emit;      // move read data into the output register
    jump_e jump;
    upc_t  target;
  } uword_t;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '0;
    w.jump = J_NONE;
    unique case (a)
      U_IDLE: begin
        w.accept = 1'b1; w.jump = J_NOSTART; w.target = U_IDLE;
      end
      U_INIT: begin
        w.init = 1'b1;
      end
      U_TEST: begin
        w.jump = J_MGTN; w.target = U_READ;
      end
      U_LOAD: begin
        w.ld_div = 1'b1;
      end
      U_DIV: begin
        w.div_step = 1'b1; w.jump = J_BITS; w.target = U_DIV;
      end
      U_NEXT: begin
        w.next_m = 1'b1; w.jump = J_ALWAYS; w.target = U_TEST;
      end
      U_READ: begin
        w.rd = 1'b1;
      end
      U_EMIT: begin
        // once the output register is free, falls through to the next step, which wraps to U_IDLE
        w.emit = 1'b1; w.jump = J_OUTBUSY; w.target = U_EMIT;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

### hdl/jos_ram.sv
module jos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/josephus_survivor.sv
// Channel   | Dir | Payload                                  | Request when
// ----------+-----+------------------------------------------+---------------------------
// s_axis    | in  | tdata[31:0] value, tlast = last          | tvalid & tready
// m_axis    | out | tdata[31:0] survivor, tuser[0] overflowed| tvalid & tready
// apb       | in  | skip_count at byte address 0 (16 bits)   | psel & penable & pwrite
//
// Loading: one value per cycle while the sequencer idles. Values past RING_DEPTH are dropped.
// Elimination: after the last item, a setup step (U_INIT), then n-1 rounds of the recurrence
//   pos = (pos + k) mod m, each passing U_TEST, U_LOAD, the bit-serial remainder unit in U_DIV
//   and U_NEXT; then the final test, the ring RAM read and the output register fill, the last
//   waiting in U_EMIT until the output register is free.
//   Input is held off (tready low) from the last item until the result is registered.
// Reset: asynchronous, active low; no clearing pass, ring entries are only read once written.
// Output stall: the result register holds until taken; a new load can proceed meanwhile.
module josephus_survivor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [jos_pkg::VALUE_W-1:0]   s_axis_tdata,   // [31:0] value
  input  logic                          s_axis_tlast,
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [jos_pkg::VALUE_W-1:0]   m_axis_tdata,   // [31:0] survivor
  output logic                          m_axis_tuser,   // [0] overflowed
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jos_pkg::PADDR_W-1:0]   paddr,
  input  logic [jos_pkg::PDATA_W-1:0]   pwdata,
  output logic [jos_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import jos_pkg::*;

  // Sequencer
  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   jump_taken;

  // Load side
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic              in_fire;
  logic              ring_we;

  // Register
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic [SKIP_W-1:0] k_eff;
  logic              cfg_wr;

  // Recurrence datapath
  logic [MW-1:0]     m_q, m_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [SUM_W-1:0]  num_q, num_d;
  logic [AW-1:0]     rem_q, rem_d;
  logic [BW-1:0]     bcnt_q, bcnt_d;
  logic [MW-1:0]     trial;
  logic [MW-1:0]     trial_sub;
  logic              m_gt_n;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  surv_q;
  logic                ovf_q;
  logic                out_free;
  logic                emit_fire;
  logic [VALUE_W-1:0]  ram_rdata;

  assign uw = ucode(upc_q);

  assign s_axis_tready = uw.accept;
  assign in_fire       = uw.accept & s_axis_tvalid;
  assign ring_we       = in_fire & (cnt_q < CW'(RING_DEPTH));

  assign k_eff = (skip_q == '0) ? SKIP_W'(1) : skip_q;

  // One restoring step: shift the next dividend bit into the remainder
  assign trial     = MW'({rem_q, num_q[SUM_W-1]});
  assign trial_sub = trial - m_q;
  assign m_gt_n    = m_q > MW'(cnt_q);

  assign out_free  = ~out_valid_q | m_axis_tready;
  assign emit_fire = uw.emit & out_free;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[PADDR_W-1:2] == REG_SKIP_COUNT);
  assign prdata = (paddr[PADDR_W-1:2] == REG_SKIP_COUNT) ? PDATA_W'(skip_q) : '0;

  jos_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (uw.rd),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // Jump evaluation
  always_comb begin
    unique case (uw.jump)
      J_NONE:    jump_taken = 1'b0;
      J_ALWAYS:  jump_taken = 1'b1;
      J_NOSTART: jump_taken = ~(in_fire & s_axis_tlast);
      J_MGTN:    jump_taken = m_gt_n;
      J_BITS:    jump_taken = (bcnt_q != '0);
      J_OUTBUSY: jump_taken = ~out_free;
      default:   jump_taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_d       = jump_taken ? uw.target : upc_q + upc_t'(1);
    skip_d      = cfg_wr ? pwdata[SKIP_W-1:0] : skip_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    m_d         = m_q;
    pos_d       = pos_q;
    num_d       = num_q;
    rem_d       = rem_q;
    bcnt_d      = bcnt_q;
    out_valid_d = out_valid_q & ~m_axis_tready;

    if (in_fire) begin
      if (ring_we) begin
        cnt_d = cnt_q + CW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
    if (uw.init) begin
      pos_d = '0;
      m_d   = MW'(2);
    end
    if (uw.ld_div) begin
      num_d  = SUM_W'(pos_q) + SUM_W'(k_eff);
      rem_d  = '0;
      bcnt_d = BW'(SUM_W - 1);
    end
    if (uw.div_step) begin
      num_d  = {num_q[SUM_W-2:0], 1'b0};
      rem_d  = (trial >= m_q) ? trial_sub[AW-1:0] : trial[AW-1:0];
      bcnt_d = bcnt_q - BW'(1);
    end
    if (uw.next_m) begin
      pos_d = rem_q;
      m_d   = m_q + MW'(1);
    end
    if (emit_fire) begin
      out_valid_d = 1'b1;
      cnt_d       = '0;
      drop_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      skip_q      <= SKIP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    pos_q  <= pos_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    bcnt_q <= bcnt_d;
    if (emit_fire) begin
      surv_q <= ram_rdata;
      ovf_q  <= drop_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = surv_q;
  assign m_axis_tuser  = ovf_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(RING_DEPTH))
    else $error("loaded count beyond ring depth");

  a_pos_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_TEST) |-> (MW'(pos_q) < m_q))
    else $error("survivor position outside current ring");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_DIV) |-> (MW'(rem_q) < m_q))
    else $error("remainder not below divisor");

  a_read_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_READ) |-> (CW'(pos_q) < cnt_q))
    else $error("read of an entry never loaded");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (cnt_q == '0) && !drop_q && m_axis_tvalid)
    else $error("result not registered or ring not emptied");

endmodule
